// ----- rtl/bdec_pkg.sv -----
// Package for the binary to decimal ASCII converter.
// Holds the sizing constants, the cell control struct and the sequencer states.
// No dependencies.
`timescale 1ns / 1ps

package bdec_pkg;

  localparam int VALUE_W    = 64;
  localparam int NUM_DIGITS = 20;
  localparam int STEP_BITS  = 4;
  localparam int CONV_STEPS = VALUE_W / STEP_BITS;
  localparam int STEP_CNT_W = $clog2(CONV_STEPS);
  localparam int COUNT_W    = 5;
  localparam int CHAR_W     = 6;

  localparam logic [CHAR_W-1:0]  ASCII_ZERO = 6'd48;
  localparam logic [COUNT_W-1:0] MAX_COUNT  = COUNT_W'(NUM_DIGITS);

  typedef logic [3:0] bcd_t;

  typedef struct packed {
    logic clear;
    logic conv;
    logic shift;
  } bdec_cell_ctl_t;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CONV = 4'b0010,
    ST_SKIP = 4'b0100,
    ST_EMIT = 4'b1000
  } bdec_state_t;

endpackage

// ----- rtl/bdec_if.sv -----
// Handshake channels of the converter: binary value in, ASCII digit out.
// Depends on bdec_pkg.
`timescale 1ns / 1ps

interface bdec_in_if
  import bdec_pkg::*;
  ();
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface bdec_out_if
  import bdec_pkg::*;
  ();
  logic               valid;
  logic               ready;
  logic [CHAR_W-1:0]  digit_char;
  logic [COUNT_W-1:0] digit_count;
  logic               last_digit;

  modport source (output valid, output digit_char, output digit_count, output last_digit,
                  input ready);
  modport sink   (input valid, input digit_char, input digit_count, input last_digit,
                  output ready);
endinterface

// ----- rtl/bdec_cell.sv -----
// One BCD digit cell of the double-dabble chain.
// Takes STEP_BITS shift-in bits per cycle from its lower neighbor, or shifts digits out.
// Depends on bdec_pkg.
`timescale 1ns / 1ps

module bdec_cell
  import bdec_pkg::*;
(
  input  logic                 clk,
  input  bdec_cell_ctl_t       ctl,
  input  logic [STEP_BITS-1:0] carry_in,
  input  bcd_t                 dig_in,
  output logic [STEP_BITS-1:0] carry_out,
  output bcd_t                 dig
);

  bcd_t dig_r;
  bcd_t dig_nxt;
  bcd_t conv_val;

  // add-3 then shift, msb-first bit order within a beat
  always_comb begin
    conv_val  = dig_r;
    carry_out = '0;
    for (int j = 0; j < STEP_BITS; j++) begin
      if (conv_val > 4'd4) begin
        conv_val = conv_val + 4'd3;
      end
      carry_out[STEP_BITS-1-j] = conv_val[3];
      conv_val = {conv_val[2:0], carry_in[STEP_BITS-1-j]};
    end
  end

  always_comb begin
    dig_nxt = dig_r;
    if (ctl.clear) begin
      dig_nxt = '0;
    end else if (ctl.conv) begin
      dig_nxt = conv_val;
    end else if (ctl.shift) begin
      dig_nxt = dig_in;
    end
  end

  always_ff @(posedge clk) begin
    dig_r <= dig_nxt;
  end

  assign dig = dig_r;

endmodule

// ----- rtl/binary_to_decimal_ascii.sv -----
// Top level: 64-bit unsigned binary to decimal ASCII text, most significant digit first.
// Built from a row of bdec_cell digit cells and a small sequencer.
// Depends on bdec_pkg, bdec_if and bdec_cell.
//
// Usage:
//   in_ch  (sink)  : one beat carries a 64-bit value; ready is high only while idle.
//   out_ch (source): one beat per decimal digit, no leading zeros, zero gives one '0'.
//                    Every beat carries the digit count; last_digit marks the final one.
// Sequence per value with n digits:
//   accept, conversion (4 bits per cycle through the 20-cell chain), dropping of leading
//   zeros (one digit shift per cycle), then n digit beats.
//   Without a stall on out_ch the time per value is independent of n.
// A new value is accepted only after the last digit beat of the previous one.
// When out_ch stalls, the current digit and all control hold until ready returns.
// Reset (rst_n low, synchronous) returns the sequencer to idle; digit cells need no reset.
`timescale 1ns / 1ps

module binary_to_decimal_ascii
  import bdec_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  bdec_in_if.sink           in_ch,
  bdec_out_if.source        out_ch
);

  bdec_state_t             state_r, state_nxt;
  logic [VALUE_W-1:0]      val_r, val_nxt;
  logic [STEP_CNT_W-1:0]   step_r, step_nxt;
  logic [COUNT_W-1:0]      ndig_r, ndig_nxt;
  logic [COUNT_W-1:0]      rem_r, rem_nxt;
  bdec_cell_ctl_t          ctl;

  logic [NUM_DIGITS-1:0][STEP_BITS-1:0] carry_in;
  logic [NUM_DIGITS-1:0][STEP_BITS-1:0] carry_out;
  bcd_t [NUM_DIGITS-1:0]                dig;
  bcd_t [NUM_DIGITS-1:0]                dig_lo;
  bcd_t                                 top_dig;

  logic in_beat;
  logic out_beat;

  assign top_dig  = dig[NUM_DIGITS-1];
  assign in_beat  = in_ch.valid && in_ch.ready;
  assign out_beat = out_ch.valid && out_ch.ready;

  // digit chain
  genvar i;
  generate
    for (i = 0; i < NUM_DIGITS; i++) begin : g_cell
      if (i == 0) begin : g_first
        assign carry_in[i] = val_r[VALUE_W-1 -: STEP_BITS];
        assign dig_lo[i]   = '0;
      end else begin : g_rest
        assign carry_in[i] = carry_out[i-1];
        assign dig_lo[i]   = dig[i-1];
      end
      bdec_cell u_cell (
        .clk       (clk),
        .ctl       (ctl),
        .carry_in  (carry_in[i]),
        .dig_in    (dig_lo[i]),
        .carry_out (carry_out[i]),
        .dig       (dig[i])
      );
    end
  endgenerate

  // sequencer
  always_comb begin
    state_nxt = state_r;
    val_nxt   = val_r;
    step_nxt  = step_r;
    ndig_nxt  = ndig_r;
    rem_nxt   = rem_r;
    ctl       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_beat) begin
          val_nxt   = in_ch.value;
          step_nxt  = '0;
          ctl.clear = 1'b1;
          state_nxt = ST_CONV;
        end
      end
      ST_CONV: begin
        ctl.conv = 1'b1;
        val_nxt  = val_r << STEP_BITS;
        step_nxt = step_r + 1'b1;
        if (step_r == STEP_CNT_W'(CONV_STEPS - 1)) begin
          ndig_nxt  = MAX_COUNT;
          state_nxt = ST_SKIP;
        end
      end
      ST_SKIP: begin
        if (top_dig == 4'd0 && ndig_r != COUNT_W'(1)) begin
          ctl.shift = 1'b1;
          ndig_nxt  = ndig_r - 1'b1;
        end else begin
          rem_nxt   = ndig_r;
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_beat) begin
          ctl.shift = 1'b1;
          rem_nxt   = rem_r - 1'b1;
          if (rem_r == COUNT_W'(1)) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
      ndig_r  <= '0;
      rem_r   <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      ndig_r  <= ndig_nxt;
      rem_r   <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign in_ch.ready        = (state_r == ST_IDLE);
  assign out_ch.valid       = (state_r == ST_EMIT);
  assign out_ch.digit_char  = ASCII_ZERO | {2'b00, top_dig};
  assign out_ch.digit_count = ndig_r;
  assign out_ch.last_digit  = (rem_r == COUNT_W'(1));

  // 20 digits always hold a 64-bit value: nothing leaves the top cell
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CONV) |-> (carry_out[NUM_DIGITS-1] == '0))
    else $error("carry out of the top digit cell");

  a_bcd_digit: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (top_dig <= 4'd9))
    else $error("digit beat outside 0..9");

  a_no_leading_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && rem_r == ndig_r && ndig_r != COUNT_W'(1)) |-> (top_dig != 4'd0))
    else $error("leading zero emitted");

  a_back_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_beat && out_ch.last_digit) |=> in_ch.ready)
    else $error("not idle after last digit");

endmodule
